### hw/rtl/scle_pkg.sv
// scle_pkg: shared types, key codes and echo prefix tables for the serial console line editor
// no dependencies

package scle_pkg;

   localparam logic [7:0] KEY_TAB = 8'd9;
   localparam logic [7:0] KEY_NL = 8'd10;
   localparam logic [7:0] KEY_ESC = 8'd27;
   localparam logic [7:0] KEY_DEL = 8'd127;
   localparam logic [7:0] KEY_LBRACKET = 8'h5B;
   localparam logic [7:0] KEY_D = 8'h44;
   localparam logic [7:0] KEY_C = 8'h43;
   localparam logic [7:0] KEY_K = 8'h4B;
   localparam logic [7:0] KEY_ZERO = 8'h30;

   localparam int LIMIT_W = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd31;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DELETE,
      OP_LEFT,
      OP_RIGHT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic [7:0] ch;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_PRE,
      ST_TAIL_RD,
      ST_TAIL_EM,
      ST_BACK,
      ST_LINE_RD,
      ST_LINE_EM,
      ST_LEN
   } state_type;

   // fixed echo bytes that open each edit
   function automatic logic [7:0] prefix_byte(op_type op, logic [2:0] pc, logic [7:0] ch);
      logic [7:0] b;
      b = KEY_ESC;
      case (op)
         OP_INSERT: begin
            case (pc)
               3'd0: b = KEY_ESC;
               3'd1: b = KEY_LBRACKET;
               3'd2: b = KEY_ZERO;
               3'd3: b = KEY_K;
               default: b = ch;
            endcase
         end
         OP_DELETE: begin
            case (pc)
               3'd0, 3'd3: b = KEY_ESC;
               3'd1, 3'd4: b = KEY_LBRACKET;
               3'd2: b = KEY_D;
               3'd5: b = KEY_ZERO;
               default: b = KEY_K;
            endcase
         end
         OP_LEFT, OP_RIGHT: begin
            case (pc)
               3'd0: b = KEY_ESC;
               3'd1: b = KEY_LBRACKET;
               default: b = (op == OP_LEFT) ? KEY_D : KEY_C;
            endcase
         end
         default: b = KEY_NL;
      endcase
      return b;
   endfunction

   function automatic logic [2:0] prefix_end(op_type op);
      logic [2:0] n;
      case (op)
         OP_INSERT: n = 3'd4;
         OP_DELETE: n = 3'd6;
         OP_LEFT, OP_RIGHT: n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/scle_front.sv
// scle_front: accepts key bytes, tracks the escape sequence and turns bytes into edit commands
// depends on scle_pkg

module scle_front
   import scle_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_key_byte,
   input logic req_end_of_input,
   input logic q_full,
   output logic push,
   output cmd_type push_cmd
);

   logic [1:0] escape_phase_ff, escape_phase_in;
   logic accept;

   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_ESC = 2'd1;
   localparam logic [1:0] PH_CSI = 2'd2;

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;

   always_comb begin
      escape_phase_in = escape_phase_ff;
      push = 1'b0;
      push_cmd.op = OP_INSERT;
      push_cmd.ch = req_key_byte;
      if (accept) begin
         escape_phase_in = PH_NONE;
         if (req_end_of_input) begin
            push = 1'b1;
            push_cmd.op = OP_FINISH;
         end else if (escape_phase_ff == PH_ESC) begin
            // lone esc goes in as a character, the byte after it is dropped
            if (req_key_byte == KEY_LBRACKET) begin
               escape_phase_in = PH_CSI;
            end else begin
               push = 1'b1;
               push_cmd.ch = KEY_ESC;
            end
         end else if (escape_phase_ff == PH_CSI) begin
            if (req_key_byte == KEY_D) begin
               push = 1'b1;
               push_cmd.op = OP_LEFT;
            end else if (req_key_byte == KEY_C) begin
               push = 1'b1;
               push_cmd.op = OP_RIGHT;
            end
         end else begin
            case (req_key_byte)
               KEY_NL: begin
                  push = 1'b1;
                  push_cmd.op = OP_FINISH;
               end
               KEY_ESC: escape_phase_in = PH_ESC;
               KEY_DEL: begin
                  push = 1'b1;
                  push_cmd.op = OP_DELETE;
               end
               KEY_TAB: push = 1'b0;
               default: push = 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_phase_ff <= PH_NONE;
      end else begin
         escape_phase_ff <= escape_phase_in;
      end
   end

endmodule

### hw/rtl/scle_queue.sv
// scle_queue: two-entry command queue between the front and the back
// depends on scle_pkg

module scle_queue
   import scle_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input cmd_type push_cmd,
   input logic pop,
   output logic q_valid,
   output logic q_full,
   output cmd_type q_cmd
);

   cmd_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign q_valid = (count_ff != 2'd0);
   assign q_full = (count_ff == 2'd2);
   assign q_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/scle_back.sv
// scle_back: carries out edit commands on the line store and sequences the echo and line beats
// depends on scle_pkg

module scle_back
   import scle_pkg::*;
#(
   parameter int LINE_SIZE = 32
) (
   input logic clock,
   input logic reset,
   input logic [LIMIT_W-1:0] line_limit,
   input logic q_valid,
   input cmd_type q_cmd,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [4:0] rsp_line_length,
   output logic rsp_last
);

   localparam int AW = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
   localparam int LIM_MAX = LINE_SIZE - 1;

   logic [7:0] line_mem [LINE_SIZE];
   logic [7:0] rd_data_ff;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0] pc_ff, pc_in;

   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [4:0] len_ff, len_in;
   logic last_ff, last_in;

   logic out_free, emit;
   logic [6:0] eff_lim, back7, ones7;
   logic [1:0] tens;
   logic at_end;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign eff_lim = (7'(line_limit) > 7'(LIM_MAX)) ? 7'(LIM_MAX) : 7'(line_limit);
   assign at_end = (cursor_ff == count_ff);

   // decimal cursor move back, at most two digits
   assign back7 = 7'(count_ff) - 7'(cursor_ff);
   always_comb begin
      if (back7 >= 7'd30) begin
         tens = 2'd3;
      end else if (back7 >= 7'd20) begin
         tens = 2'd2;
      end else if (back7 >= 7'd10) begin
         tens = 2'd1;
      end else begin
         tens = 2'd0;
      end
   end
   assign ones7 = back7 - 7'(tens) * 7'd10;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cursor_in = cursor_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pc_in = pc_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff;
      emit = 1'b0;
      kind_in = KIND_ECHO;
      data_in = 8'd0;
      len_in = 5'd0;
      last_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               cmd_in = q_cmd;
               pc_in = 3'd0;
               case (q_cmd.op)
                  OP_INSERT: begin
                     if (7'(count_ff) < eff_lim) begin
                        idx_in = count_ff;
                        state_in = (count_ff > cursor_ff) ? ST_SHIFT_RD : ST_PUT;
                     end
                  end
                  OP_DELETE: begin
                     if (cursor_ff != '0 && count_ff != '0) begin
                        cursor_in = AW'(cursor_ff - 1'b1);
                        idx_in = AW'(cursor_ff - 1'b1);
                        if (cursor_ff < count_ff) begin
                           state_in = ST_SHIFT_RD;
                        end else begin
                           count_in = AW'(count_ff - 1'b1);
                           state_in = ST_PRE;
                        end
                     end
                  end
                  OP_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in = AW'(cursor_ff - 1'b1);
                        state_in = ST_PRE;
                     end
                  end
                  OP_RIGHT: begin
                     if (cursor_ff < count_ff) begin
                        cursor_in = AW'(cursor_ff + 1'b1);
                        state_in = ST_PRE;
                     end
                  end
                  default: state_in = ST_PRE;
               endcase
            end
         end

         ST_SHIFT_RD: begin
            // insert moves entries up from the end, delete moves them down from the cursor
            rd_en = 1'b1;
            rd_addr = (cmd_ff.op == OP_INSERT) ? AW'(idx_ff - 1'b1) : AW'(idx_ff + 1'b1);
            state_in = ST_SHIFT_WR;
         end

         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if (cmd_ff.op == OP_INSERT) begin
               idx_in = AW'(idx_ff - 1'b1);
               state_in = (AW'(idx_ff - 1'b1) > cursor_ff) ? ST_SHIFT_RD : ST_PUT;
            end else begin
               idx_in = AW'(idx_ff + 1'b1);
               if (7'(idx_ff) + 7'd2 < 7'(count_ff)) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  count_in = AW'(count_ff - 1'b1);
                  state_in = ST_PRE;
               end
            end
         end

         ST_PUT: begin
            wr_en = 1'b1;
            wr_addr = cursor_ff;
            wr_data = cmd_ff.ch;
            cursor_in = AW'(cursor_ff + 1'b1);
            count_in = AW'(count_ff + 1'b1);
            state_in = ST_PRE;
         end

         ST_PRE: begin
            if (out_free) begin
               emit = 1'b1;
               data_in = prefix_byte(cmd_ff.op, pc_ff, cmd_ff.ch);
               pc_in = pc_ff + 3'd1;
               if (pc_ff == prefix_end(cmd_ff.op)) begin
                  case (cmd_ff.op)
                     OP_INSERT, OP_DELETE: begin
                        last_in = at_end;
                        idx_in = cursor_ff;
                        state_in = at_end ? ST_IDLE : ST_TAIL_RD;
                     end
                     OP_LEFT, OP_RIGHT: begin
                        last_in = 1'b1;
                        state_in = ST_IDLE;
                     end
                     default: begin
                        idx_in = '0;
                        state_in = (count_ff != '0) ? ST_LINE_RD : ST_LEN;
                     end
                  endcase
               end
            end
         end

         ST_TAIL_RD: begin
            rd_en = 1'b1;
            state_in = ST_TAIL_EM;
         end

         ST_TAIL_EM: begin
            if (out_free) begin
               emit = 1'b1;
               data_in = rd_data_ff;
               idx_in = AW'(idx_ff + 1'b1);
               pc_in = 3'd0;
               state_in = (7'(idx_ff) + 7'd1 < 7'(count_ff)) ? ST_TAIL_RD : ST_BACK;
            end
         end

         ST_BACK: begin
            if (out_free) begin
               emit = 1'b1;
               case (pc_ff)
                  3'd0: begin
                     data_in = KEY_ESC;
                     pc_in = 3'd1;
                  end
                  3'd1: begin
                     data_in = KEY_LBRACKET;
                     pc_in = (tens != 2'd0) ? 3'd2 : 3'd3;
                  end
                  3'd2: begin
                     data_in = KEY_ZERO + 8'(tens);
                     pc_in = 3'd3;
                  end
                  3'd3: begin
                     data_in = KEY_ZERO + 8'(ones7);
                     pc_in = 3'd4;
                  end
                  default: begin
                     data_in = KEY_D;
                     last_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_LINE_RD: begin
            rd_en = 1'b1;
            state_in = ST_LINE_EM;
         end

         ST_LINE_EM: begin
            if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_LINE;
               data_in = rd_data_ff;
               idx_in = AW'(idx_ff + 1'b1);
               state_in = (7'(idx_ff) + 7'd1 < 7'(count_ff)) ? ST_LINE_RD : ST_LEN;
            end
         end

         ST_LEN: begin
            if (out_free) begin
               emit = 1'b1;
               kind_in = KIND_END;
               len_in = 5'(count_ff);
               last_in = 1'b1;
               cursor_in = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      pc_ff <= pc_in;
      if (emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff <= len_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cursor_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cursor_ff <= cursor_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_line_length = len_ff;
   assign rsp_last = last_ff;

endmodule

### hw/rtl/serial_console_line_editor_top.sv
// serial_console_line_editor_top: line editor with ansi echo, front, queue and back sequencer
// depends on scle_pkg, scle_front, scle_queue, scle_back
//
// Usage: key bytes come in on the req_ channel (valid/stall); each beat is a byte or an
// end-of-input mark. Echo bytes, finished line bytes and the line end come out one per beat on
// the rsp_ channel, with rsp_last on the final beat an input causes. csr_write_en loads the
// line limit (reset 31); the user loads it only while the block is idle, which is not enforced.
// The front classifies a beat in the cycle it is taken and queues a command (two deep); req_stall
// is high only while that queue is full. The back takes one command at a time, popping it in its
// idle state. An insert or delete moves each line entry it shifts with a memory read state and
// then a write state (an insert then writes its character), then gives one beat per fixed echo
// byte and reads each tail or line byte from memory before emitting it.
// rsp_stall holds the output register and the back waits at its next beat; the front keeps
// taking beats until the queue fills. Reset empties the queue, clears the line, cursor and
// escape state and drops any pending output beat; the line memory itself is not cleared.

module serial_console_line_editor_top
   import scle_pkg::*;
#(
   parameter int LINE_SIZE = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_key_byte,
   input logic req_end_of_input,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [4:0] rsp_line_length,
   output logic rsp_last,
   input logic csr_write_en,
   input logic [LIMIT_W-1:0] csr_write_data
);

   logic [LIMIT_W-1:0] line_limit_ff;
   logic push, pop, q_valid, q_full;
   cmd_type push_cmd, q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff <= LIMIT_RESET;
      end else if (csr_write_en) begin
         line_limit_ff <= csr_write_data;
      end
   end

   scle_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_key_byte(req_key_byte),
      .req_end_of_input(req_end_of_input),
      .q_full(q_full),
      .push(push),
      .push_cmd(push_cmd)
   );

   scle_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .q_valid(q_valid),
      .q_full(q_full),
      .q_cmd(q_cmd)
   );

   scle_back #(
      .LINE_SIZE(LINE_SIZE)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .line_limit(line_limit_ff),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_line_length(rsp_line_length),
      .rsp_last(rsp_last)
   );

   // a line end always closes the response of its input
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_last && rsp_data_byte == 8'd0)
      else $error("line end beat without last or with data");

   // only line ends carry a length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_END |-> rsp_line_length == 5'd0)
      else $error("length on a non line end beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_ECHO || rsp_kind == KIND_LINE || rsp_kind == KIND_END)
      else $error("undefined result kind");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output beat survived reset");

endmodule

### tb/serial_console_line_editor_top_test.sv
// serial_console_line_editor_top_test: checks the line editor against a behavioral predictor
// of its echo, line and line-end beats; depends on scle_pkg and serial_console_line_editor_top
`timescale 1ns / 100ps

module serial_console_line_editor_top_test;
   import scle_pkg::*;

   typedef struct {
      logic [7:0] key;
      logic eoi;
   } key_beat_t;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic [4:0] len;
      logic last;
   } out_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_key_byte = '0;
   logic req_end_of_input = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [4:0] rsp_line_length;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic [LIMIT_W-1:0] csr_write_data = '0;

   serial_console_line_editor_top dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [7:0] line_buf [0:31];
   int cur_pos, char_cnt, esc_phase, lim;

   key_beat_t pending_keys[$];
   out_beat_t echo_expect[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0, gap_left = 0;
   int stall_phase = 0;

   function automatic void push_beat(logic [1:0] k, logic [7:0] d, logic [4:0] n);
      out_beat_t b;
      b.kind = k; b.data = d; b.len = n; b.last = 1'b0;
      echo_expect.push_back(b);
   endfunction

   function automatic void echo_tail_back();
      int back;
      for (int i = cur_pos; i < char_cnt; i++) push_beat(KIND_ECHO, line_buf[i], 0);
      if (cur_pos < char_cnt) begin
         back = char_cnt - cur_pos;
         push_beat(KIND_ECHO, KEY_ESC, 0);
         push_beat(KIND_ECHO, KEY_LBRACKET, 0);
         if (back >= 10) push_beat(KIND_ECHO, 8'(KEY_ZERO + back / 10), 0);
         push_beat(KIND_ECHO, 8'(KEY_ZERO + back % 10), 0);
         push_beat(KIND_ECHO, KEY_D, 0);
      end
   endfunction

   function automatic void insert_key(logic [7:0] c);
      if (char_cnt >= lim) return;
      for (int i = char_cnt; i > cur_pos; i--) line_buf[i] = line_buf[i-1];
      line_buf[cur_pos] = c;
      cur_pos++; char_cnt++;
      push_beat(KIND_ECHO, KEY_ESC, 0);
      push_beat(KIND_ECHO, KEY_LBRACKET, 0);
      push_beat(KIND_ECHO, KEY_ZERO, 0);
      push_beat(KIND_ECHO, KEY_K, 0);
      push_beat(KIND_ECHO, c, 0);
      echo_tail_back();
   endfunction

   function automatic void finish_line();
      push_beat(KIND_ECHO, KEY_NL, 0);
      for (int i = 0; i < char_cnt; i++) push_beat(KIND_LINE, line_buf[i], 0);
      push_beat(KIND_END, 0, 5'(char_cnt));
      cur_pos = 0; char_cnt = 0; esc_phase = 0;
   endfunction

   function automatic void predict_key(key_beat_t kb);
      int n_prior;
      n_prior = echo_expect.size();
      if (kb.eoi) finish_line();
      else if (esc_phase == 1) begin
         esc_phase = 0;
         if (kb.key == KEY_LBRACKET) esc_phase = 2;
         else insert_key(KEY_ESC);
      end else if (esc_phase == 2) begin
         esc_phase = 0;
         if (kb.key == KEY_D && cur_pos > 0) begin
            cur_pos--;
            push_beat(KIND_ECHO, KEY_ESC, 0);
            push_beat(KIND_ECHO, KEY_LBRACKET, 0);
            push_beat(KIND_ECHO, KEY_D, 0);
         end else if (kb.key == KEY_C && cur_pos < char_cnt) begin
            cur_pos++;
            push_beat(KIND_ECHO, KEY_ESC, 0);
            push_beat(KIND_ECHO, KEY_LBRACKET, 0);
            push_beat(KIND_ECHO, KEY_C, 0);
         end
      end else if (kb.key == KEY_NL) finish_line();
      else if (kb.key == KEY_ESC) esc_phase = 1;
      else if (kb.key == KEY_DEL) begin
         if (cur_pos > 0 && char_cnt > 0) begin
            cur_pos--;
            for (int i = cur_pos; i + 1 < char_cnt; i++) line_buf[i] = line_buf[i+1];
            char_cnt--;
            push_beat(KIND_ECHO, KEY_ESC, 0);
            push_beat(KIND_ECHO, KEY_LBRACKET, 0);
            push_beat(KIND_ECHO, KEY_D, 0);
            push_beat(KIND_ECHO, KEY_ESC, 0);
            push_beat(KIND_ECHO, KEY_LBRACKET, 0);
            push_beat(KIND_ECHO, KEY_ZERO, 0);
            push_beat(KIND_ECHO, KEY_K, 0);
            echo_tail_back();
         end
      end else if (kb.key != KEY_TAB) insert_key(kb.key);
      if (echo_expect.size() > n_prior) echo_expect[echo_expect.size()-1].last = 1'b1;
   endfunction

   function automatic void add_key(logic [7:0] k, logic e = 1'b0);
      key_beat_t kb;
      kb.key = k; kb.eoi = e;
      pending_keys.push_back(kb);
   endfunction

   // mostly printable text with edits, escapes, and occasional noise
   function automatic void add_random_key();
      int r;
      r = $urandom_range(99);
      if (r < 50) add_key(8'($urandom_range(32, 126)));
      else if (r < 62) begin add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_D); end
      else if (r < 70) begin add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_C); end
      else if (r < 78) add_key(KEY_DEL);
      else if (r < 83) add_key(KEY_NL);
      else if (r < 85) add_key(8'($urandom), 1'b1);
      else if (r < 88) add_key(KEY_TAB);
      else if (r < 91) begin add_key(KEY_ESC); add_key(8'($urandom)); end
      else if (r < 93) begin add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(8'($urandom)); end
      else add_key(8'($urandom));
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_key('{key: req_key_byte, eoi: req_end_of_input});
         void'(pending_keys.pop_front());
         if (pending_keys.size() > 0 && burst_left > 0) begin
            burst_left <= burst_left - 1;
            req_key_byte <= pending_keys[0].key;
            req_end_of_input <= pending_keys[0].eoi;
         end else begin
            req_valid <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         end
      end else if (!req_valid && pending_keys.size() > 0) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else begin
            req_valid <= 1'b1;
            req_key_byte <= pending_keys[0].key;
            req_end_of_input <= pending_keys[0].eoi;
            burst_left <= $urandom_range(0, 12);
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         stall_phase <= (stall_phase + 1) % 64;
         rsp_stall <= (stall_phase < 24) ? ($urandom_range(2) == 0) : 1'b0;
         if (rsp_valid && !rsp_stall) begin
            if (echo_expect.size() == 0) begin
               $error("unexpected beat kind %0d data %0h", rsp_kind, rsp_data_byte);
               errors++;
            end else begin
               out_beat_t x;
               x = echo_expect.pop_front();
               if (rsp_kind !== x.kind) begin
                  $error("kind exp %0d got %0d", x.kind, rsp_kind); errors++;
               end
               if (rsp_data_byte !== x.data) begin
                  $error("data_byte exp %0h got %0h", x.data, rsp_data_byte); errors++;
               end
               if (rsp_line_length !== x.len) begin
                  $error("line_length exp %0d got %0d", x.len, rsp_line_length); errors++;
               end
               if (rsp_last !== x.last) begin
                  $error("last exp %0d got %0d", x.last, rsp_last); errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("serial_console_line_editor_top_test: errors");
         $finish;
      end
   end

   task automatic drain_and_set_limit(int value);
      while (pending_keys.size() > 0 || req_valid || echo_expect.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= 5'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      lim = value;
   endtask

   initial begin
      cur_pos = 0; char_cnt = 0; esc_phase = 0; lim = 31;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      drain_and_set_limit(31);
      // directed: inserts, edge moves, del at start, tab, escapes, full line, finish
      add_key(KEY_DEL); add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_D);
      add_key(8'h00); add_key(8'hFF); add_key(KEY_TAB); add_key(8'h41);
      add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_D);
      add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_C);
      add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_C);
      add_key(KEY_DEL); add_key(KEY_ESC); add_key(8'h55);
      add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(8'h7A);
      add_key(KEY_ESC); add_key(8'h00, 1'b1);
      drain_and_set_limit(1);
      add_key(8'h31); add_key(8'h32); add_key(KEY_ESC); add_key(KEY_NL); add_key(KEY_NL);
      drain_and_set_limit(0);
      add_key(8'h31); add_key(8'h00, 1'b1);
      drain_and_set_limit(31);
      for (int i = 0; i < 34; i++) add_key(8'($urandom_range(32, 126)));
      for (int i = 0; i < 12; i++) begin
         add_key(KEY_ESC); add_key(KEY_LBRACKET); add_key(KEY_D);
      end
      add_key(8'h21); add_key(KEY_DEL);
      drain_and_set_limit(3);
      add_key(KEY_NL);
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 10; i++) add_random_key();
         drain_and_set_limit(p == 3 ? 31 : $urandom_range(1, 31));
      end
      if (errors == 0) $display("serial_console_line_editor_top_test: clean");
      else $display("serial_console_line_editor_top_test: errors");
      $finish;
   end
endmodule
